FILE: hw/rtl/lrmt_pkg.sv
package lrmt_pkg;

  localparam int LEVELS   = 10;
  localparam int LEAVES   = 1 << LEVELS;
  localparam int POS_W    = LEVELS + 1;
  localparam int ADDR_W   = LEVELS + 1;
  localparam int NODE_W   = LEVELS + 2;
  localparam int PEND_W   = LEVELS;
  localparam int LV_W     = $clog2(LEVELS + 1);
  localparam int VAL_W    = 32;
  localparam int TYPE_W   = 3;
  localparam int PH_W     = 2;
  localparam int IN_BITS  = 2 * POS_W + 2 * VAL_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = VAL_W + 2 * POS_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [TYPE_W-1:0] {
    REQ_READ   = 3'd0,
    REQ_WRITE  = 3'd1,
    REQ_ADD    = 3'd2,
    REQ_QUERY  = 3'd3,
    REQ_PREFIX = 3'd4,
    REQ_SUFFIX = 3'd5
  } req_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_PUSH,
    OP_PULL,
    OP_ADD,
    OP_LOOK,
    OP_WRITE,
    OP_ACC,
    OP_OUT
  } dp_op_t;

  typedef enum logic [1:0] {
    OUT_ZERO,
    OUT_NODE,
    OUT_SUM,
    OUT_FOUND
  } out_sel_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_PUSH,
    S_PT_LOOK,
    S_PT_WRITE,
    S_PULL,
    S_RG_STEP,
    S_RG_A,
    S_RG_AACC,
    S_RG_CHKB,
    S_RG_B,
    S_RG_BACC,
    S_SR_DEC,
    S_SR_CLIMB,
    S_SR_LOOK,
    S_SR_TEST,
    S_SR_DESC,
    S_SR_DLOOK,
    S_SR_DTEST,
    S_OUT
  } state_t;

  typedef struct packed {
    dp_op_t            op;
    logic [NODE_W-1:0] node;
    out_sel_t          sel;
    logic              bad;
    logic [POS_W-1:0]  found;
    logic              load;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic ok;
  } dp_stat_t;

  typedef struct packed {
    logic [VAL_W-1:0] mx;
    logic [POS_W-1:0] cnt;
  } pair_t;

  function automatic logic sgt(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    sgt = $signed(a) > $signed(b);
  endfunction

  function automatic pair_t comb_pair(pair_t a, pair_t b);
    pair_t r;
    r.mx  = sgt(a.mx, b.mx) ? a.mx : b.mx;
    r.cnt = a.cnt + b.cnt;
    comb_pair = r;
  endfunction

endpackage

FILE: hw/rtl/lrmt_dp.sv
module lrmt_dp
  import lrmt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [VAL_W-1:0]    in_value,
  input  logic [VAL_W-1:0]    in_threshold,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [VAL_W-1:0]    out_max,
  output logic [POS_W-1:0]    out_cnt,
  output logic [POS_W-1:0]    out_found,
  output logic                out_bad
);

  logic [VAL_W-1:0]  mem_max  [2*LEAVES];
  logic [POS_W-1:0]  mem_cnt  [2*LEAVES];
  logic [VAL_W-1:0]  mem_pend [LEAVES];

  logic [ADDR_W-1:0] max_ra, max_wa, cnt_ra, cnt_wa;
  logic [PEND_W-1:0] pend_ra, pend_wa;
  logic [VAL_W-1:0]  max_wd, pend_wd;
  logic [POS_W-1:0]  cnt_wd;
  logic              max_we, cnt_we, pend_we;
  logic [VAL_W-1:0]  max_rd, pend_rd;
  logic [POS_W-1:0]  cnt_rd;

  logic [PH_W-1:0]   ph;
  logic [VAL_W-1:0]  tmx;
  logic [POS_W-1:0]  tcn;
  pair_t             nd, cr, sum;
  logic              ok;
  logic [VAL_W-1:0]  val, thr;
  logic              done;

  logic [ADDR_W-1:0] addr, c0, c1;
  logic [PEND_W-1:0] pidx, c0p, c1p;
  logic              own_pend, child_pend;
  pair_t             rd_pair, pull_pair;

  assign addr       = cmd.node[ADDR_W-1:0];
  assign c0         = {cmd.node[ADDR_W-2:0], 1'b0};
  assign c1         = {cmd.node[ADDR_W-2:0], 1'b1};
  assign pidx       = cmd.node[PEND_W-1:0];
  assign c0p        = c0[PEND_W-1:0];
  assign c1p        = c1[PEND_W-1:0];
  assign own_pend   = cmd.node < NODE_W'(LEAVES);
  assign child_pend = cmd.node < NODE_W'(LEAVES / 2);
  assign rd_pair    = '{mx: max_rd, cnt: cnt_rd};
  assign pull_pair  = comb_pair('{mx: tmx, cnt: tcn}, rd_pair);

  always_comb begin
    max_ra  = addr;
    cnt_ra  = addr;
    pend_ra = pidx;
    max_we  = 1'b0;
    max_wa  = addr;
    max_wd  = '0;
    cnt_we  = 1'b0;
    cnt_wa  = addr;
    cnt_wd  = '0;
    pend_we = 1'b0;
    pend_wa = pidx;
    pend_wd = '0;
    done    = 1'b0;
    unique case (cmd.op)
      OP_CLEAR: begin
        max_we  = 1'b1;
        cnt_we  = 1'b1;
        pend_we = 1'b1;
        done    = 1'b1;
      end
      OP_WRITE: begin
        max_we = 1'b1;
        max_wd = val;
        cnt_we = 1'b1;
        cnt_wd = POS_W'(1);
        done   = 1'b1;
      end
      OP_ACC: done = 1'b1;
      OP_OUT: done = !out_valid || out_ready;
      OP_ADD: begin
        if (ph != '0) begin
          max_we  = 1'b1;
          max_wd  = max_rd + val;
          pend_we = own_pend;
          pend_wd = pend_rd + val;
          done    = 1'b1;
        end
      end
      OP_LOOK: done = (ph == PH_W'(2));
      OP_PULL: begin
        if (ph == PH_W'(0)) begin
          max_ra = c0;
          cnt_ra = c0;
        end else if (ph == PH_W'(1)) begin
          max_ra = c1;
          cnt_ra = c1;
        end else begin
          max_we = 1'b1;
          max_wd = pull_pair.mx;
          cnt_we = 1'b1;
          cnt_wd = pull_pair.cnt;
          done   = 1'b1;
        end
      end
      OP_PUSH: begin
        if (ph == PH_W'(0)) begin
          max_ra = c0;
        end else if (ph == PH_W'(1)) begin
          max_we  = 1'b1;
          max_wa  = c0;
          max_wd  = max_rd + pend_rd;
          pend_we = 1'b1;
          max_ra  = c1;
          pend_ra = c0p;
        end else if (ph == PH_W'(2)) begin
          max_we  = 1'b1;
          max_wa  = c1;
          max_wd  = max_rd + tmx;
          pend_we = child_pend;
          pend_wa = c0p;
          pend_wd = pend_rd + tmx;
          pend_ra = c1p;
        end else begin
          pend_we = child_pend;
          pend_wa = c1p;
          pend_wd = pend_rd + tmx;
          done    = 1'b1;
        end
      end
      default: done = 1'b0;
    endcase
  end

  assign stat = '{done: done, ok: ok};

  // tree storage
  always_ff @(posedge clk) begin
    if (max_we) begin
      mem_max[max_wa] <= max_wd;
    end
    max_rd <= mem_max[max_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      mem_cnt[cnt_wa] <= cnt_wd;
    end
    cnt_rd <= mem_cnt[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (pend_we) begin
      mem_pend[pend_wa] <= pend_wd;
    end
    pend_rd <= mem_pend[pend_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_NONE || cmd.op == OP_OUT || done) begin
        ph <= '0;
      end else begin
        ph <= ph + PH_W'(1);
      end
      if (cmd.op == OP_OUT && done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val <= in_value;
      thr <= in_threshold;
      sum <= '0;
    end
    if (cmd.op == OP_PUSH && ph == PH_W'(1)) begin
      tmx <= pend_rd;
    end
    if (cmd.op == OP_PULL && ph == PH_W'(1)) begin
      tmx <= max_rd;
      tcn <= cnt_rd;
    end
    if (cmd.op == OP_LOOK && ph == PH_W'(1)) begin
      nd <= rd_pair;
      cr <= comb_pair(sum, rd_pair);
    end
    if (cmd.op == OP_LOOK && ph == PH_W'(2)) begin
      ok <= (cr.cnt == '0) || sgt(cr.mx, VAL_W'(cr.cnt) + thr);
    end
    if (cmd.op == OP_ACC) begin
      sum <= cr;
    end
    if (cmd.op == OP_OUT && done) begin
      out_bad <= cmd.bad;
      unique case (cmd.sel)
        OUT_NODE: begin
          out_max   <= nd.mx;
          out_cnt   <= nd.cnt;
          out_found <= '0;
        end
        OUT_SUM: begin
          out_max   <= sum.mx;
          out_cnt   <= sum.cnt;
          out_found <= '0;
        end
        OUT_FOUND: begin
          out_max   <= '0;
          out_cnt   <= '0;
          out_found <= cmd.found;
        end
        OUT_ZERO: begin
          out_max   <= '0;
          out_cnt   <= '0;
          out_found <= '0;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/lrmt_ctrl.sv
module lrmt_ctrl
  import lrmt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TYPE_W-1:0] in_type,
  input  logic [POS_W-1:0]  in_left,
  input  logic [POS_W-1:0]  in_right,
  input  logic              cfg_we,
  input  logic [POS_W-1:0]  cfg_wdata,
  output dp_cmd_t           cmd,
  input  dp_stat_t          stat
);

  localparam logic [NODE_W-1:0] LEAF0 = NODE_W'(LEAVES);

  state_t             state, state_next;
  logic [TYPE_W-1:0]  typ;
  logic [POS_W-1:0]   pl, pr, n, found;
  logic [NODE_W-1:0]  lo, hi, a, b;
  logic [LV_W-1:0]    lv;
  logic               side, bad_r;
  logic [ADDR_W-1:0]  ccnt;

  logic [NODE_W-1:0]  lmask, node0, node1, ap1, a_off;
  logic               lo_rem, hi_rem, is_range, is_prefix;
  logic               push_need, pull_need, push_adv, pull_adv;
  logic               pow2_a, pow2_ap1, dec_bad, done, ok;

  assign done      = stat.done;
  assign ok        = stat.ok;
  assign lmask     = (NODE_W'(1) << lv) - NODE_W'(1);
  assign lo_rem    = (lo & lmask) != '0;
  assign hi_rem    = (hi & lmask) != '0;
  assign node0     = lo >> lv;
  assign node1     = (hi - NODE_W'(1)) >> lv;
  assign is_range  = (typ == REQ_ADD) || (typ == REQ_QUERY);
  assign is_prefix = (typ == REQ_PREFIX);
  assign push_need = side ? (is_range ? hi_rem : (typ == REQ_SUFFIX))
                          : (is_range ? lo_rem : (typ != REQ_SUFFIX));
  assign pull_need = side ? ((typ == REQ_ADD) && hi_rem)
                          : ((typ == REQ_WRITE) || lo_rem);
  assign push_adv  = !push_need || done;
  assign pull_adv  = !pull_need || done;
  assign ap1       = a + NODE_W'(1);
  assign pow2_a    = (a & (~a + NODE_W'(1))) == a;
  assign pow2_ap1  = (ap1 & (~ap1 + NODE_W'(1))) == ap1;
  assign a_off     = a - LEAF0;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    unique case (typ)
      REQ_READ, REQ_WRITE: dec_bad = pl >= n;
      REQ_ADD, REQ_QUERY:  dec_bad = (pl > pr) || (pr > n);
      REQ_PREFIX:          dec_bad = pl > n;
      REQ_SUFFIX:          dec_bad = pr > n;
      default:             dec_bad = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (ccnt == '1) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_DEC;
      S_DEC: begin
        if (dec_bad) begin
          state_next = S_OUT;
        end else if (is_range && pl == pr) begin
          state_next = S_OUT;
        end else if (is_prefix && pl == n) begin
          state_next = S_OUT;
        end else if (typ == REQ_SUFFIX && pr == '0) begin
          state_next = S_OUT;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (push_adv && side && lv == LV_W'(1)) begin
          unique case (typ)
            REQ_READ:   state_next = S_PT_LOOK;
            REQ_WRITE:  state_next = S_PT_WRITE;
            REQ_PREFIX: state_next = S_SR_CLIMB;
            REQ_SUFFIX: state_next = S_SR_DEC;
            default:    state_next = S_RG_STEP;
          endcase
        end
      end
      S_PT_LOOK:  if (done) state_next = S_OUT;
      S_PT_WRITE: if (done) state_next = S_PULL;
      S_PULL:     if (pull_adv && side && lv == LV_W'(LEVELS)) state_next = S_OUT;
      S_RG_STEP: begin
        if (a < b) begin
          state_next = a[0] ? S_RG_A : S_RG_CHKB;
        end else begin
          state_next = (typ == REQ_ADD) ? S_PULL : S_OUT;
        end
      end
      S_RG_A:    if (done) state_next = (typ == REQ_ADD) ? S_RG_CHKB : S_RG_AACC;
      S_RG_AACC: state_next = S_RG_CHKB;
      S_RG_CHKB: state_next = b[0] ? S_RG_B : S_RG_STEP;
      S_RG_B:    if (done) state_next = (typ == REQ_ADD) ? S_RG_STEP : S_RG_BACC;
      S_RG_BACC: state_next = S_RG_STEP;
      S_SR_DEC:  state_next = S_SR_CLIMB;
      S_SR_CLIMB: begin
        if (is_prefix ? a[0] : !(a > NODE_W'(1) && a[0])) state_next = S_SR_LOOK;
      end
      S_SR_LOOK: if (done) state_next = S_SR_TEST;
      S_SR_TEST: begin
        if (!ok) begin
          state_next = S_SR_DESC;
        end else if (is_prefix) begin
          state_next = pow2_ap1 ? S_OUT : S_SR_CLIMB;
        end else begin
          state_next = pow2_a ? S_OUT : S_SR_DEC;
        end
      end
      S_SR_DESC: begin
        if (a >= LEAF0) begin
          state_next = S_OUT;
        end else if (done) begin
          state_next = S_SR_DLOOK;
        end
      end
      S_SR_DLOOK: if (done) state_next = S_SR_DTEST;
      S_SR_DTEST: state_next = S_SR_DESC;
      S_OUT:      if (done) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd       = '0;
    cmd.op    = OP_NONE;
    cmd.sel   = OUT_ZERO;
    cmd.bad   = bad_r;
    cmd.found = found;
    cmd.load  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.op   = OP_CLEAR;
        cmd.node = NODE_W'(ccnt);
      end
      S_IDLE: cmd.load = in_valid;
      S_PUSH: begin
        cmd.op   = push_need ? OP_PUSH : OP_NONE;
        cmd.node = side ? node1 : node0;
      end
      S_PULL: begin
        cmd.op   = pull_need ? OP_PULL : OP_NONE;
        cmd.node = side ? node1 : node0;
      end
      S_PT_LOOK: begin
        cmd.op   = OP_LOOK;
        cmd.node = lo;
      end
      S_PT_WRITE: begin
        cmd.op   = OP_WRITE;
        cmd.node = lo;
      end
      S_RG_A: begin
        cmd.op   = (typ == REQ_ADD) ? OP_ADD : OP_LOOK;
        cmd.node = a;
      end
      S_RG_B: begin
        cmd.op   = (typ == REQ_ADD) ? OP_ADD : OP_LOOK;
        cmd.node = b;
      end
      S_RG_AACC, S_RG_BACC: cmd.op = OP_ACC;
      S_SR_LOOK, S_SR_DLOOK: begin
        cmd.op   = OP_LOOK;
        cmd.node = a;
      end
      S_SR_TEST, S_SR_DTEST: cmd.op = ok ? OP_ACC : OP_NONE;
      S_SR_DESC: begin
        cmd.op   = (a < LEAF0) ? OP_PUSH : OP_NONE;
        cmd.node = a;
      end
      S_OUT: begin
        cmd.op = OP_OUT;
        if (bad_r) begin
          cmd.sel = OUT_ZERO;
        end else begin
          unique case (typ)
            REQ_READ:               cmd.sel = OUT_NODE;
            REQ_QUERY:              cmd.sel = OUT_SUM;
            REQ_PREFIX, REQ_SUFFIX: cmd.sel = OUT_FOUND;
            default:                cmd.sel = OUT_ZERO;
          endcase
        end
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ccnt  <= '0;
      n     <= POS_W'(LEAVES);
      lv    <= '0;
      side  <= 1'b0;
      bad_r <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        n <= (cfg_wdata > POS_W'(LEAVES)) ? POS_W'(LEAVES) : cfg_wdata;
      end
      unique case (state)
        S_CLEAR: ccnt <= ccnt + ADDR_W'(1);
        S_IDLE: begin
          if (in_valid) begin
            typ   <= in_type;
            pl    <= in_left;
            pr    <= in_right;
            bad_r <= 1'b0;
          end
        end
        S_DEC: begin
          bad_r <= dec_bad;
          lv    <= LV_W'(LEVELS);
          side  <= 1'b0;
          lo    <= NODE_W'(pl) + LEAF0;
          hi    <= NODE_W'(pr) + LEAF0;
          if (is_prefix) begin
            a     <= NODE_W'(pl) + LEAF0;
            found <= n;
          end else begin
            a     <= NODE_W'(pr) + LEAF0;
            found <= '0;
          end
        end
        S_PUSH: begin
          if (push_adv) begin
            side <= !side;
            if (side) begin
              if (lv == LV_W'(1)) begin
                if (is_range) begin
                  a <= lo;
                  b <= hi;
                end
              end else begin
                lv <= lv - LV_W'(1);
              end
            end
          end
        end
        S_PT_WRITE: begin
          lv   <= LV_W'(1);
          side <= 1'b0;
        end
        S_PULL: begin
          if (pull_adv) begin
            side <= !side;
            if (side) lv <= lv + LV_W'(1);
          end
        end
        S_RG_STEP: begin
          lv   <= LV_W'(1);
          side <= 1'b0;
        end
        S_RG_A: if (done && typ == REQ_ADD) a <= ap1;
        S_RG_AACC: a <= ap1;
        S_RG_CHKB: begin
          if (b[0]) begin
            b <= b - NODE_W'(1);
          end else begin
            a <= a >> 1;
            b <= b >> 1;
          end
        end
        S_RG_B: begin
          if (done && typ == REQ_ADD) begin
            a <= a >> 1;
            b <= b >> 1;
          end
        end
        S_RG_BACC: begin
          a <= a >> 1;
          b <= b >> 1;
        end
        S_SR_DEC: a <= a - NODE_W'(1);
        S_SR_CLIMB: begin
          if (is_prefix ? !a[0] : (a > NODE_W'(1) && a[0])) a <= a >> 1;
        end
        S_SR_TEST: begin
          if (ok) begin
            if (is_prefix) begin
              a     <= ap1;
              found <= n;
            end else begin
              found <= '0;
            end
          end
        end
        S_SR_DESC: begin
          if (a >= LEAF0) begin
            if (is_prefix) begin
              found <= (a_off < NODE_W'(n)) ? POS_W'(a_off) : n;
            end else begin
              found <= POS_W'(a_off + NODE_W'(1));
            end
          end else if (done) begin
            a <= is_prefix ? {a[NODE_W-2:0], 1'b0} : {a[NODE_W-2:0], 1'b1};
          end
        end
        S_SR_DTEST: begin
          if (ok) a <= is_prefix ? ap1 : (a - NODE_W'(1));
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/lazy_range_add_max_tree_core.sv
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    requests: s_tdata, s_tuser
// m_        out  m_tvalid/m_tready    results:  m_tdata, m_tuser
// cfg_      in   cfg_we               num_leaves on cfg_wdata
//
// after reset a clearing pass writes all 2048 node entries, one per cycle;
// s_tready stays low throughout that pass, cfg writes are taken as ever
// one request at a time: each push or pull of a node steps through read and
// write phases on the node memories, which have separate read and write ports
// a finished result sits in the output register while the next request runs

module lazy_range_add_max_tree_core
  import lrmt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [IN_W-1:0]    s_tdata,   // pos_left, pos_right, value, threshold
  input  logic [TYPE_W-1:0]  s_tuser,   // req_type
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_W-1:0]   m_tdata,   // max_value, leaf_count, found_index
  output logic               m_tuser,   // bad_request
  input  logic               cfg_we,
  input  logic [POS_W-1:0]   cfg_wdata
);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [VAL_W-1:0] out_max;
  logic [POS_W-1:0] out_cnt, out_found;

  lrmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_type   (s_tuser),
    .in_left   (s_tdata[POS_W-1:0]),
    .in_right  (s_tdata[2*POS_W-1:POS_W]),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

  lrmt_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_value     (s_tdata[2*POS_W +: VAL_W]),
    .in_threshold (s_tdata[2*POS_W+VAL_W +: VAL_W]),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_max      (out_max),
    .out_cnt      (out_cnt),
    .out_found    (out_found),
    .out_bad      (m_tuser)
  );

  assign m_tdata = {(OUT_W - OUT_BITS)'(0), out_found, out_cnt, out_max};

endmodule

FILE: hw/rtl/lrmt_checker.sv
module lrmt_checker
  import lrmt_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [OUT_W-1:0]   m_tdata,
  input logic               m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("rejected request carries data");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2*POS_W+VAL_W-1:POS_W+VAL_W] <= POS_W'(LEAVES)
             && m_tdata[POS_W+VAL_W-1:VAL_W] <= POS_W'(LEAVES))
    else $error("count or index out of range");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_tready)
    else $error("request taken during clearing pass");

endmodule

bind lazy_range_add_max_tree_core lrmt_checker u_chk (.*);

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import lrmt_pkg::*;

  localparam logic [TYPE_W-1:0] REQ_BAD6 = 3'd6;
  localparam logic [TYPE_W-1:0] REQ_BAD7 = 3'd7;
  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD  = 700;
  localparam int TAIL_WAIT  = 400;

  typedef enum logic [1:0] {K_REQ, K_CFG, K_HOLD} kind_t;

  typedef struct {
    kind_t             kind;
    logic [TYPE_W-1:0] typ;
    logic [POS_W-1:0]  l;
    logic [POS_W-1:0]  r;
    logic [VAL_W-1:0]  val;
    logic [VAL_W-1:0]  thr;
  } item_t;

  typedef struct {
    logic [VAL_W-1:0] mx;
    logic [POS_W-1:0] ct;
    logic [POS_W-1:0] found;
    logic             bad;
  } answer_t;

  typedef struct {
    logic [31:0] mx;
    logic [31:0] ct;
  } acc_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic [TYPE_W-1:0] s_tuser;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tuser;
  logic             cfg_we;
  logic [POS_W-1:0] cfg_wdata;

  lazy_range_add_max_tree_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  item_t       req_backlog[$];
  answer_t     tree_answers[$];
  item_t       cur_req;
  int          errors = 0;
  int          sent = 0;
  int          got = 0;
  int          snd_gap = 0;
  int          rcv_gap = 0;
  int          idle_cycles = 0;
  int unsigned gen_n = LEAVES;
  logic        v_n, we_n, r_n;

  // predictor state
  logic [31:0] nmx[0:2*LEAVES-1];
  logic [31:0] nct[0:2*LEAVES-1];
  logic [31:0] pend[0:LEAVES-1];
  int unsigned nl;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit sg(logic [31:0] a, logic [31:0] b);
    return $signed(a) > $signed(b);
  endfunction

  function automatic acc_t merge_acc(acc_t a, acc_t b);
    acc_t s;
    s.mx = sg(a.mx, b.mx) ? a.mx : b.mx;
    s.ct = a.ct + b.ct;
    return s;
  endfunction

  function automatic acc_t node_acc(int unsigned i);
    acc_t s;
    s.mx = nmx[i];
    s.ct = nct[i];
    return s;
  endfunction

  function automatic bit passes(acc_t s, logic [31:0] thr);
    return s.ct == 0 || sg(s.mx, s.ct + thr);
  endfunction

  function automatic void apply_add(int unsigned i, logic [31:0] f);
    nmx[i] += f;
    if (i < LEAVES) pend[i] += f;
  endfunction

  function automatic void push_node(int unsigned i);
    apply_add(2 * i, pend[i]);
    apply_add(2 * i + 1, pend[i]);
    pend[i] = 0;
  endfunction

  function automatic void pull_node(int unsigned i);
    acc_t s;
    s = merge_acc(node_acc(2 * i), node_acc(2 * i + 1));
    nmx[i] = s.mx;
    nct[i] = s.ct;
  endfunction

  function automatic int unsigned prefix_find(int unsigned l, logic [31:0] thr);
    acc_t s;
    int unsigned i;
    s = '{0, 0};
    if (l == nl) return nl;
    l += LEAVES;
    for (i = LEVELS; i >= 1; i--) push_node(l >> i);
    do begin
      while ((l & 1) == 0) l >>= 1;
      if (!passes(merge_acc(s, node_acc(l)), thr)) begin
        while (l < LEAVES) begin
          push_node(l);
          l <<= 1;
          if (passes(merge_acc(s, node_acc(l)), thr)) begin
            s = merge_acc(s, node_acc(l));
            l++;
          end
        end
        l -= LEAVES;
        return (l < nl) ? l : nl;
      end
      s = merge_acc(s, node_acc(l));
      l++;
    end while ((l & (32'd0 - l)) != l);
    return nl;
  endfunction

  function automatic int unsigned suffix_find(int unsigned r, logic [31:0] thr);
    acc_t s;
    int unsigned i;
    s = '{0, 0};
    if (r == 0) return 0;
    r += LEAVES;
    for (i = LEVELS; i >= 1; i--) push_node((r - 1) >> i);
    do begin
      r--;
      while (r > 1 && (r & 1)) r >>= 1;
      if (!passes(merge_acc(node_acc(r), s), thr)) begin
        while (r < LEAVES) begin
          push_node(r);
          r = 2 * r + 1;
          if (passes(merge_acc(node_acc(r), s), thr)) begin
            s = merge_acc(node_acc(r), s);
            r--;
          end
        end
        return r + 1 - LEAVES;
      end
      s = merge_acc(node_acc(r), s);
    end while ((r & (32'd0 - r)) != r);
    return 0;
  endfunction

  function automatic answer_t tree_predict(item_t it);
    answer_t a;
    acc_t s;
    int unsigned l, r, i, lo, hi;
    a = '{0, 0, 0, 0};
    s = '{0, 0};
    l = it.l;
    r = it.r;
    case (it.typ)
      REQ_READ, REQ_WRITE: begin
        if (l >= nl) begin
          a.bad = 1'b1;
        end else begin
          l += LEAVES;
          for (i = LEVELS; i >= 1; i--) push_node(l >> i);
          if (it.typ == REQ_READ) begin
            a.mx = nmx[l];
            a.ct = nct[l][POS_W-1:0];
          end else begin
            nmx[l] = it.val;
            nct[l] = 1;
            for (i = 1; i <= LEVELS; i++) pull_node(l >> i);
          end
        end
      end
      REQ_ADD, REQ_QUERY: begin
        if (l > r || r > nl) begin
          a.bad = 1'b1;
        end else if (l != r) begin
          l += LEAVES;
          r += LEAVES;
          for (i = LEVELS; i >= 1; i--) begin
            if (((l >> i) << i) != l) push_node(l >> i);
            if (((r >> i) << i) != r) push_node((r - 1) >> i);
          end
          for (lo = l, hi = r; lo < hi; lo >>= 1, hi >>= 1) begin
            if (lo & 1) begin
              if (it.typ == REQ_ADD) apply_add(lo, it.val);
              else s = merge_acc(s, node_acc(lo));
              lo++;
            end
            if (hi & 1) begin
              hi--;
              if (it.typ == REQ_ADD) apply_add(hi, it.val);
              else s = merge_acc(node_acc(hi), s);
            end
          end
          if (it.typ == REQ_QUERY) begin
            a.mx = s.mx;
            a.ct = s.ct[POS_W-1:0];
          end else begin
            for (i = 1; i <= LEVELS; i++) begin
              if (((l >> i) << i) != l) pull_node(l >> i);
              if (((r >> i) << i) != r) pull_node((r - 1) >> i);
            end
          end
        end
      end
      REQ_PREFIX: begin
        if (l > nl) a.bad = 1'b1;
        else a.found = POS_W'(prefix_find(l, it.thr));
      end
      REQ_SUFFIX: begin
        if (r > nl) a.bad = 1'b1;
        else a.found = POS_W'(suffix_find(r, it.thr));
      end
      default: a.bad = 1'b1;
    endcase
    return a;
  endfunction

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic add_req(logic [TYPE_W-1:0] t, int unsigned l, int unsigned r,
                         logic [31:0] v, logic [31:0] thr);
    item_t it;
    it = '{K_REQ, t, l[POS_W-1:0], r[POS_W-1:0], v, thr};
    req_backlog.push_back(it);
  endtask

  task automatic add_cfg(int unsigned v);
    item_t it;
    it = '{K_CFG, REQ_READ, v[POS_W-1:0], 0, 0, 0};
    req_backlog.push_back(it);
    gen_n = (v > LEAVES) ? LEAVES : v;
  endtask

  task automatic add_hold();
    item_t it;
    it = '{K_HOLD, REQ_READ, 0, 0, 0, 0};
    req_backlog.push_back(it);
  endtask

  function automatic logic [31:0] rand_val();
    if ($urandom_range(0, 1)) return $urandom();
    return $urandom_range(0, 40) - 20;
  endfunction

  task automatic rand_phase(int count);
    int unsigned t, l, r, k;
    for (k = 0; k < count; k++) begin
      t = $urandom_range(0, 99);
      if (t < 25) t = REQ_WRITE;
      else if (t < 45) t = REQ_ADD;
      else if (t < 60) t = REQ_QUERY;
      else if (t < 75) t = REQ_READ;
      else if (t < 86) t = REQ_PREFIX;
      else if (t < 97) t = REQ_SUFFIX;
      else t = $urandom_range(REQ_BAD6, REQ_BAD7);
      if ($urandom_range(0, 19) == 0) begin
        l = $urandom_range(0, 2047);
        r = $urandom_range(0, 2047);
      end else if (t == REQ_READ || t == REQ_WRITE) begin
        l = (gen_n > 0) ? $urandom_range(0, gen_n - 1) : 0;
        r = $urandom_range(0, 2047);
      end else begin
        l = $urandom_range(0, gen_n);
        r = $urandom_range(l, gen_n);
      end
      add_req(TYPE_W'(t), l, r, rand_val(),
              $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 10) - 5);
    end
  endtask

  function automatic int draw_gap(int n);
    if ((n / 100) % 3 == 0) return 0;
    return $urandom_range(0, 10);
  endfunction

  // request and cfg write driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      cfg_we   <= 1'b0;
    end else begin
      v_n  = s_tvalid;
      we_n = 1'b0;
      if (s_tvalid && s_tready) begin
        tree_answers.push_back(tree_predict(cur_req));
        sent++;
        v_n = 1'b0;
        snd_gap = draw_gap(sent);
      end
      if (!v_n) begin
        if (snd_gap > 0) begin
          snd_gap--;
        end else if (req_backlog.size() > 0) begin
          case (req_backlog[0].kind)
            K_REQ: begin
              cur_req = req_backlog.pop_front();
              v_n = 1'b1;
              s_tdata <= {{(IN_W-IN_BITS){1'b0}}, cur_req.thr, cur_req.val,
                          cur_req.r, cur_req.l};
              s_tuser <= cur_req.typ;
            end
            K_CFG: begin
              if (tree_answers.size() == 0) begin
                cur_req = req_backlog.pop_front();
                we_n = 1'b1;
                cfg_wdata <= cur_req.l;
                nl = (cur_req.l > LEAVES) ? LEAVES : cur_req.l;
              end
            end
            default: begin
              if (tree_answers.size() == 0) void'(req_backlog.pop_front());
            end
          endcase
        end
      end
      s_tvalid <= v_n;
      cfg_we   <= we_n;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      r_n = m_tready;
      if (m_tvalid && m_tready) begin
        if (tree_answers.size() == 0) begin
          report("result with no request outstanding");
        end else begin
          answer_t e;
          e = tree_answers.pop_front();
          if (m_tdata[VAL_W-1:0] !== e.mx)
            report($sformatf("max_value %h, expected %h", m_tdata[VAL_W-1:0], e.mx));
          if (m_tdata[VAL_W+POS_W-1:VAL_W] !== e.ct)
            report($sformatf("leaf_count %0d, expected %0d",
                             m_tdata[VAL_W+POS_W-1:VAL_W], e.ct));
          if (m_tdata[VAL_W+2*POS_W-1:VAL_W+POS_W] !== e.found)
            report($sformatf("found_index %0d, expected %0d",
                             m_tdata[VAL_W+2*POS_W-1:VAL_W+POS_W], e.found));
          if (m_tuser !== e.bad)
            report($sformatf("bad_request %b, expected %b", m_tuser, e.bad));
        end
        got++;
        rcv_gap = (got == 150) ? LONG_HOLD : draw_gap(got + 50);
        r_n = (rcv_gap == 0);
      end else if (!m_tready) begin
        if (rcv_gap > 0) rcv_gap--;
        if (rcv_gap == 0) r_n = 1'b1;
      end
      m_tready <= r_n;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    nl = LEAVES;
    for (int i = 0; i < 2 * LEAVES; i++) begin
      nmx[i] = 0;
      nct[i] = 0;
    end
    for (int i = 0; i < LEAVES; i++) pend[i] = 0;

    // directed: extremes, every request kind, rejects
    add_req(REQ_READ, 0, 0, 0, 0);
    add_req(REQ_WRITE, 0, 0, 32'h7fffffff, 0);
    add_req(REQ_WRITE, 1023, 0, 32'h80000000, 0);
    add_req(REQ_READ, 1023, 0, 0, 0);
    add_req(REQ_QUERY, 0, 1024, 0, 0);
    add_req(REQ_ADD, 0, 1024, 32'hffffffff, 0);
    add_req(REQ_ADD, 5, 700, 32'd3, 0);
    add_req(REQ_ADD, 9, 9, 32'd5, 0);
    add_req(REQ_QUERY, 0, 1024, 0, 0);
    add_req(REQ_QUERY, 500, 500, 0, 0);
    add_req(REQ_READ, 600, 0, 0, 0);
    add_req(REQ_PREFIX, 0, 0, 0, 32'h80000000);
    add_req(REQ_PREFIX, 0, 0, 0, 32'h7fffffff);
    add_req(REQ_PREFIX, 1024, 0, 0, 0);
    add_req(REQ_SUFFIX, 0, 1024, 0, 0);
    add_req(REQ_SUFFIX, 0, 0, 0, 0);
    add_req(REQ_READ, 1024, 0, 0, 0);
    add_req(REQ_WRITE, 2047, 0, 32'hffffffff, 0);
    add_req(REQ_ADD, 10, 3, 1, 0);
    add_req(REQ_QUERY, 0, 1025, 0, 0);
    add_req(REQ_PREFIX, 1025, 0, 0, 0);
    add_req(REQ_SUFFIX, 0, 2047, 0, 0);
    add_req(REQ_BAD6, 0, 0, 0, 0);
    add_req(REQ_BAD7, 2047, 2047, 32'hffffffff, 32'hffffffff);

    rand_phase(250);
    add_hold();
    rand_phase(150);
    add_cfg(2047);
    rand_phase(100);
    add_cfg(0);
    rand_phase(30);
    add_cfg(1);
    rand_phase(60);
    add_cfg(37);
    rand_phase(200);
    add_cfg(513);
    rand_phase(200);
    add_cfg(1000);
    rand_phase(300);
    add_cfg(1024);
    rand_phase(200);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (req_backlog.size() != 0 || s_tvalid || tree_answers.size() != 0);
    repeat (TAIL_WAIT) @(posedge clk);
    if (errors == 0 && tree_answers.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
